// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the charge-end capacity RTL.
// Expects clk and arst_n in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== rtl/core/cecb_pkg.sv =====
// Constants, widths and lookup tables for the charge-end capacity block.
// No dependencies; used by cecb_div and charge_end_capacity_bilinear.
package cecb_pkg;

	localparam int VOLT_POINTS = 8;
	localparam int TEMP_POINTS = 8;
	localparam int VIDX_W      = $clog2(VOLT_POINTS);
	localparam int TIDX_W      = $clog2(TEMP_POINTS);

	localparam int V_W     = 13;
	localparam int T_W     = 8;
	localparam int CAP_W   = 16;
	localparam int FAC_W   = 16;
	localparam int TAB_W   = 14;
	localparam int U_W     = 13;
	localparam int W_W     = 7;
	localparam int DV_W    = 8;
	localparam int DT_W    = 4;
	localparam int DEN_W   = DV_W + DT_W;
	localparam int LO_W    = 24;
	localparam int P_W     = 32;

	localparam int DIV_QW  = 16;
	localparam int DIV_DW  = 17;
	localparam int DIV_NW  = DIV_DW + DIV_QW;
	localparam int DIV_LAT = DIV_QW + 1;
	localparam int LATENCY = 5 + 2 * DIV_LAT;

	localparam int APB_DW  = 32;
	localparam int ADDR_W  = 3;

	localparam logic REG_FULL_CAP = 1'b0;
	localparam logic [CAP_W-1:0] FULL_CAP_RST = CAP_W'(12000);

	localparam logic [V_W-1:0] VOLT_BP [VOLT_POINTS] = '{
		13'd3389, 13'd3399, 13'd3403, 13'd3422, 13'd3440, 13'd3475, 13'd3630, 13'd3650
	};

	localparam logic signed [T_W-1:0] TEMP_BP [TEMP_POINTS] = '{
		8'sd0, 8'sd5, 8'sd10, 8'sd15, 8'sd20, 8'sd25, 8'sd35, 8'sd45
	};

	// rows: temperature, columns: voltage
	localparam logic [TAB_W-1:0] CAP_TAB [TEMP_POINTS][VOLT_POINTS] = '{
		'{14'd6989,  14'd7429,  14'd7718,  14'd9350,
		  14'd10541, 14'd11360, 14'd11878, 14'd11900},
		'{14'd7596,  14'd8030,  14'd8692,  14'd10437,
		  14'd11178, 14'd11675, 14'd12000, 14'd12000},
		'{14'd8179,  14'd9878,  14'd10557, 14'd11446,
		  14'd11786, 14'd12000, 14'd12000, 14'd12000},
		'{14'd9932,  14'd11100, 14'd11360, 14'd11812,
		  14'd12000, 14'd12000, 14'd12000, 14'd12000},
		'{14'd10784, 14'd11527, 14'd11728, 14'd12000,
		  14'd12000, 14'd12000, 14'd12000, 14'd12000},
		'{14'd11458, 14'd11884, 14'd12000, 14'd12000,
		  14'd12000, 14'd12000, 14'd12000, 14'd12000},
		'{14'd11919, 14'd12000, 14'd12000, 14'd12000,
		  14'd12000, 14'd12000, 14'd12000, 14'd12000},
		'{14'd12000, 14'd12000, 14'd12000, 14'd12000,
		  14'd12000, 14'd12000, 14'd12000, 14'd12000}
	};

endpackage

// ===== rtl/core/cecb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on cecb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cecb_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [cecb_pkg::DIV_NW-1:0]   num,
	input  logic [cecb_pkg::DIV_DW-1:0]   den,
	output logic                          out_valid,
	output logic [cecb_pkg::DIV_QW-1:0]   quo
);

	localparam int L = cecb_pkg::DIV_LAT - 1;

	logic [cecb_pkg::DIV_LAT-1:0]  vld_s;
	logic [cecb_pkg::DIV_NW-1:0]   rem_s [cecb_pkg::DIV_LAT];
	logic [cecb_pkg::DIV_DW-1:0]   den_s [cecb_pkg::DIV_LAT];
	logic [cecb_pkg::DIV_QW-1:0]   quo_s [cecb_pkg::DIV_LAT];
	logic                          sat_s [cecb_pkg::DIV_LAT];
	logic                          sat_in;
	logic                          rem_ok;

	assign sat_in = num >= {den, {cecb_pkg::DIV_QW{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[cecb_pkg::DIV_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		sat_s[0] <= sat_in;
	end

	for (genvar p = 1; p < cecb_pkg::DIV_LAT; p++) begin : g_bit
		localparam int K = cecb_pkg::DIV_LAT - 1 - p;
		logic [cecb_pkg::DIV_NW-1:0] sub;
		logic                        take;

		assign sub  = cecb_pkg::DIV_NW'(den_s[p-1]) << K;
		assign take = rem_s[p-1] >= sub;

		always_ff @(posedge clk) begin
			den_s[p] <= den_s[p-1];
			sat_s[p] <= sat_s[p-1];
			rem_s[p] <= take ? rem_s[p-1] - sub : rem_s[p-1];
			quo_s[p] <= take ? quo_s[p-1] | (cecb_pkg::DIV_QW'(1) << K) : quo_s[p-1];
		end
	end

	assign out_valid = vld_s[L];
	assign quo       = sat_s[L] ? '1 : quo_s[L];
	assign rem_ok    = rem_s[L] < cecb_pkg::DIV_NW'(den_s[L]);

	`ASSERT_PROP(a_div_latency, out_valid |-> $past(in_valid, cecb_pkg::DIV_LAT),
		"divider output without matching input")
	`ASSERT_PROP(a_div_saturate, in_valid && sat_in |-> ##(cecb_pkg::DIV_LAT) quo == '1,
		"overflowing quotient not saturated")
	`ASSERT_NEVER(a_div_remainder, out_valid && !sat_s[L] && !rem_ok,
		"final remainder not below divisor")

endmodule

// ===== rtl/core/charge_end_capacity_bilinear.sv =====
// Top level: charge-end capacity by bilinear interpolation in an 8x8 table.
// Depends on cecb_pkg, cecb_div and assert_macros.svh.
//
//   channel   handshake                      payload
//   input     start (taken when busy low)    cell_voltage_mv, temperature_c
//   result    done, one cycle                capacity_centi_ah, capacity_factor_q15
//   config    APB access, pready always high full_capacity_centi_ah at byte 0
//
// One word per cycle in; each result passes 5 interpolation stages and then two
// 17-stage dividers (capacity, then factor).
// busy is always low: the pipeline never stalls since done cannot be held off.
// Reset clears the valid bits and loads full capacity with 12000.
`include "assert_macros.svh"

module charge_end_capacity_bilinear (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic        [cecb_pkg::V_W-1:0]     cell_voltage_mv,
	input  logic signed [cecb_pkg::T_W-1:0]     temperature_c,
	output logic                                done,
	output logic        [cecb_pkg::CAP_W-1:0]   capacity_centi_ah,
	output logic        [cecb_pkg::FAC_W-1:0]   capacity_factor_q15,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [cecb_pkg::ADDR_W-1:0]  paddr,
	input  logic        [cecb_pkg::APB_DW-1:0]  pwdata,
	output logic        [cecb_pkg::APB_DW-1:0]  prdata,
	output logic                                pready
);

	logic [cecb_pkg::CAP_W-1:0] full_q;
	logic                       reg_idx;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic        [cecb_pkg::VIDX_W-1:0] vidx_c, vidx_s1;
	logic        [cecb_pkg::TIDX_W-1:0] tidx_c, tidx_s1;
	logic        [cecb_pkg::V_W-1:0]    vc_c, vc_s1;
	logic signed [cecb_pkg::T_W-1:0]    tc_c, tc_s1;

	logic        [cecb_pkg::VIDX_W-1:0] vlo;
	logic        [cecb_pkg::TIDX_W-1:0] tlo;
	logic        [cecb_pkg::U_W-1:0]    u_c, u_s2;
	logic        [cecb_pkg::W_W-1:0]    w_c, w_s2, w_s3;
	logic        [cecb_pkg::DV_W-1:0]   dv_c, dv_s2;
	logic        [cecb_pkg::DT_W-1:0]   dt_c, dt_s2, dt_s3;
	logic        [cecb_pkg::DEN_W-1:0]  den_c, den_s2, den_s3, den_s4, den_s5;
	logic        [cecb_pkg::TAB_W-1:0]  a00_c, a10_c, a00_s2, a10_s2;
	logic signed [cecb_pkg::TAB_W:0]    d0_c, d1_c, d0_s2, d1_s2;

	logic signed [cecb_pkg::P_W-1:0]    m0, m1, m2, m3;
	logic signed [cecb_pkg::LO_W-1:0]   lo_c, hi_c, lo_s3, hi_s3;
	logic signed [cecb_pkg::P_W-1:0]    hl, plo_c, pw_c, plo_s4, pw_s4;
	logic signed [cecb_pkg::P_W-1:0]    num_s5;

	logic [cecb_pkg::DIV_NW-1:0] cdiv_num, fdiv_num;
	logic [cecb_pkg::DIV_DW-1:0] cdiv_den, fdiv_den;
	logic                        cdiv_vld, fdiv_vld;
	logic [cecb_pkg::DIV_QW-1:0] cap_c, fac_c;
	logic [cecb_pkg::CAP_W-1:0]  capd_s [cecb_pkg::DIV_LAT];

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[cecb_pkg::ADDR_W-1];
	assign prdata  = (reg_idx == cecb_pkg::REG_FULL_CAP) ? cecb_pkg::APB_DW'(full_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= cecb_pkg::FULL_CAP_RST;
		end else if (psel && penable && pwrite && pready
		             && reg_idx == cecb_pkg::REG_FULL_CAP) begin
			full_q <= pwdata[cecb_pkg::CAP_W-1:0];
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: clamp and locate segments
	always_comb begin
		vidx_c = cecb_pkg::VIDX_W'(1);
		tidx_c = cecb_pkg::TIDX_W'(1);
		for (int k = 1; k < cecb_pkg::VOLT_POINTS - 1; k++) begin
			if (cell_voltage_mv > cecb_pkg::VOLT_BP[k])
				vidx_c = vidx_c + cecb_pkg::VIDX_W'(1);
		end
		for (int k = 1; k < cecb_pkg::TEMP_POINTS - 1; k++) begin
			if (temperature_c > cecb_pkg::TEMP_BP[k])
				tidx_c = tidx_c + cecb_pkg::TIDX_W'(1);
		end
		vc_c = (cell_voltage_mv < cecb_pkg::VOLT_BP[0]) ? cecb_pkg::VOLT_BP[0] : cell_voltage_mv;
		tc_c = (temperature_c < cecb_pkg::TEMP_BP[0]) ? cecb_pkg::TEMP_BP[0] : temperature_c;
	end

	always_ff @(posedge clk) begin
		vidx_s1 <= vidx_c;
		tidx_s1 <= tidx_c;
		vc_s1   <= vc_c;
		tc_s1   <= tc_c;
	end

	// stage 2: table corners, offsets and segment widths
	always_comb begin
		vlo   = vidx_s1 - cecb_pkg::VIDX_W'(1);
		tlo   = tidx_s1 - cecb_pkg::TIDX_W'(1);
		u_c   = cecb_pkg::U_W'(vc_s1 - cecb_pkg::VOLT_BP[vlo]);
		w_c   = cecb_pkg::W_W'(tc_s1 - cecb_pkg::TEMP_BP[tlo]);
		dv_c  = cecb_pkg::DV_W'(cecb_pkg::VOLT_BP[vidx_s1] - cecb_pkg::VOLT_BP[vlo]);
		dt_c  = cecb_pkg::DT_W'(cecb_pkg::TEMP_BP[tidx_s1] - cecb_pkg::TEMP_BP[tlo]);
		den_c = cecb_pkg::DEN_W'(dv_c * dt_c);
		a00_c = cecb_pkg::CAP_TAB[tlo][vlo];
		a10_c = cecb_pkg::CAP_TAB[tidx_s1][vlo];
		d0_c  = $signed({1'b0, cecb_pkg::CAP_TAB[tlo][vidx_s1]}) - $signed({1'b0, a00_c});
		d1_c  = $signed({1'b0, cecb_pkg::CAP_TAB[tidx_s1][vidx_s1]}) - $signed({1'b0, a10_c});
	end

	always_ff @(posedge clk) begin
		u_s2   <= u_c;
		w_s2   <= w_c;
		dv_s2  <= dv_c;
		dt_s2  <= dt_c;
		den_s2 <= den_c;
		a00_s2 <= a00_c;
		a10_s2 <= a10_c;
		d0_s2  <= d0_c;
		d1_s2  <= d1_c;
	end

	// stage 3: interpolate along voltage on both temperature rows
	always_comb begin
		m0   = cecb_pkg::P_W'($signed({1'b0, a00_s2}) * $signed({1'b0, dv_s2}));
		m1   = cecb_pkg::P_W'($signed({1'b0, u_s2}) * d0_s2);
		m2   = cecb_pkg::P_W'($signed({1'b0, a10_s2}) * $signed({1'b0, dv_s2}));
		m3   = cecb_pkg::P_W'($signed({1'b0, u_s2}) * d1_s2);
		lo_c = cecb_pkg::LO_W'(m0 + m1);
		hi_c = cecb_pkg::LO_W'(m2 + m3);
	end

	always_ff @(posedge clk) begin
		lo_s3  <= lo_c;
		hi_s3  <= hi_c;
		w_s3   <= w_s2;
		dt_s3  <= dt_s2;
		den_s3 <= den_s2;
	end

	// stage 4: weight along temperature
	always_comb begin
		hl    = cecb_pkg::P_W'(hi_s3) - cecb_pkg::P_W'(lo_s3);
		plo_c = cecb_pkg::P_W'(lo_s3 * $signed({1'b0, dt_s3}));
		pw_c  = cecb_pkg::P_W'($signed({1'b0, w_s3}) * hl);
	end

	always_ff @(posedge clk) begin
		plo_s4 <= plo_c;
		pw_s4  <= pw_c;
		den_s4 <= den_s3;
	end

	// stage 5: numerator
	always_ff @(posedge clk) begin
		num_s5 <= plo_s4 + pw_s4;
		den_s5 <= den_s4;
	end

	// round half up: (2*num + den) / (2*den); non-positive numerator gives zero
	assign cdiv_num = (num_s5 > 0)
		? (cecb_pkg::DIV_NW'(num_s5) << 1) + cecb_pkg::DIV_NW'(den_s5) : '0;
	assign cdiv_den = cecb_pkg::DIV_DW'({den_s5, 1'b0});

	cecb_div u_cap_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.num       (cdiv_num),
		.den       (cdiv_den),
		.out_valid (cdiv_vld),
		.quo       (cap_c)
	);

	// factor: (cap * 65536 + full) / (2 * full); zero full saturates
	assign fdiv_num = {1'b0, cap_c, {cecb_pkg::CAP_W{1'b0}}} + cecb_pkg::DIV_NW'(full_q);
	assign fdiv_den = {full_q, 1'b0};

	cecb_div u_fac_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cdiv_vld),
		.num       (fdiv_num),
		.den       (fdiv_den),
		.out_valid (fdiv_vld),
		.quo       (fac_c)
	);

	always_ff @(posedge clk) begin
		capd_s[0] <= cap_c;
		for (int k = 1; k < cecb_pkg::DIV_LAT; k++)
			capd_s[k] <= capd_s[k-1];
	end

	assign done                = fdiv_vld;
	assign capacity_centi_ah   = capd_s[cecb_pkg::DIV_LAT-1];
	assign capacity_factor_q15 = fac_c;

	`ASSERT_PROP(a_done_latency, done |-> $past(start, cecb_pkg::LATENCY),
		"result without a start word")
	`ASSERT_PROP(a_zero_full, done && full_q == '0 |-> capacity_factor_q15 == '1,
		"zero full capacity must saturate the factor")
	`ASSERT_NEVER(a_zero_cap, done && capacity_centi_ah == '0 && full_q != '0
		&& capacity_factor_q15 != '0, "zero capacity with nonzero factor")

endmodule

// ===== tb/sv/cecb_capacity_check.sv =====
// Checker for charge_end_capacity_bilinear: predicts capacity and Q1.15 factor per word.
// Tracks APB writes to the full-capacity register and checks register reads.
// Depends on cecb_pkg for port widths and the register index.
module cecb_capacity_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic        [cecb_pkg::V_W-1:0]     cell_voltage_mv,
	input  logic signed [cecb_pkg::T_W-1:0]     temperature_c,
	input  logic                                done,
	input  logic        [cecb_pkg::CAP_W-1:0]   capacity_centi_ah,
	input  logic        [cecb_pkg::FAC_W-1:0]   capacity_factor_q15,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic        [cecb_pkg::ADDR_W-1:0]  paddr,
	input  logic        [cecb_pkg::APB_DW-1:0]  pwdata,
	input  logic        [cecb_pkg::APB_DW-1:0]  prdata,
	input  logic                                pready,
	output int                                  fail_count,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cecb_pkg::ADDR_W-1:0] FULL_CAP_ADDR =
		cecb_pkg::ADDR_W'(4 * cecb_pkg::REG_FULL_CAP);
	localparam logic [15:0] FULL_CAP_RESET = 16'd12000;
	localparam int KNOTS = 8;

	localparam int VOLT_KNOT [KNOTS] = '{3389, 3399, 3403, 3422, 3440, 3475, 3630, 3650};
	localparam int TEMP_KNOT [KNOTS] = '{0, 5, 10, 15, 20, 25, 35, 45};
	localparam int CAP_GRID [KNOTS][KNOTS] = '{
		'{ 6989,  7429,  7718,  9350, 10541, 11360, 11878, 11900},
		'{ 7596,  8030,  8692, 10437, 11178, 11675, 12000, 12000},
		'{ 8179,  9878, 10557, 11446, 11786, 12000, 12000, 12000},
		'{ 9932, 11100, 11360, 11812, 12000, 12000, 12000, 12000},
		'{10784, 11527, 11728, 12000, 12000, 12000, 12000, 12000},
		'{11458, 11884, 12000, 12000, 12000, 12000, 12000, 12000},
		'{11919, 12000, 12000, 12000, 12000, 12000, 12000, 12000},
		'{12000, 12000, 12000, 12000, 12000, 12000, 12000, 12000}
	};

	typedef struct packed {
		logic [12:0] mv;
		logic [7:0]  deg;
		logic [15:0] cap;
		logic [15:0] fac;
	} capacity_word_t;

	capacity_word_t capacity_q [$];
	logic [15:0] full_cap;

	initial fail_count = 0;

	// returns {capacity, factor}
	function automatic logic [31:0] predict_capacity(input logic [12:0] mv,
			input logic signed [7:0] deg, input logic [15:0] full);
		longint v, t, dv, dt, u, w, a00, a01, a10, a11, lo, hi, num, den, q, cap, fac;
		int i, j;
		v = mv;
		t = deg;
		if (v <= VOLT_KNOT[0]) begin
			v = VOLT_KNOT[0];
			i = 1;
		end else if (v >= VOLT_KNOT[KNOTS-1]) begin
			i = KNOTS - 1;
		end else begin
			i = 1;
			while (v > VOLT_KNOT[i]) i++;
		end
		if (t <= TEMP_KNOT[0]) begin
			t = TEMP_KNOT[0];
			j = 1;
		end else if (t >= TEMP_KNOT[KNOTS-1]) begin
			j = KNOTS - 1;
		end else begin
			j = 1;
			while (t > TEMP_KNOT[j]) j++;
		end
		dv = VOLT_KNOT[i] - VOLT_KNOT[i-1];
		dt = TEMP_KNOT[j] - TEMP_KNOT[j-1];
		u = v - VOLT_KNOT[i-1];
		w = t - TEMP_KNOT[j-1];
		a00 = CAP_GRID[j-1][i-1];
		a01 = CAP_GRID[j-1][i];
		a10 = CAP_GRID[j][i-1];
		a11 = CAP_GRID[j][i];
		lo = a00 * dv + u * (a01 - a00);
		hi = a10 * dv + u * (a11 - a10);
		num = lo * dt + w * (hi - lo);
		den = dv * dt;
		if (den <= 0 || num <= 0) begin
			cap = 0;
		end else begin
			q = (num * 2 + den) / (den * 2);
			cap = (q > 65535) ? 65535 : q;
		end
		if (full == 16'd0) begin
			fac = 65535;
		end else begin
			fac = (cap * 65536 + longint'(full)) / (longint'(full) * 2);
			if (fac > 65535)
				fac = 65535;
		end
		return {cap[15:0], fac[15:0]};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		capacity_word_t got_word;
		logic [31:0] pair;
		int errs;
		errs = 0;
		if (!arst_n) begin
			capacity_q.delete();
			full_cap <= FULL_CAP_RESET;
			pending <= 0;
		end else begin
			if (done) begin
				if (capacity_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got capacity %0d factor %0d",
						$time, capacity_centi_ah, capacity_factor_q15);
					errs = errs + 1;
				end else begin
					got_word = capacity_q.pop_front();
					if (capacity_centi_ah !== got_word.cap) begin
						$display("%0t: capacity for %0d mV %0d C: expected %0d, got %0d",
							$time, got_word.mv, $signed(got_word.deg), got_word.cap,
							capacity_centi_ah);
						errs = errs + 1;
					end
					if (capacity_factor_q15 !== got_word.fac) begin
						$display("%0t: factor for %0d mV %0d C: expected %0d, got %0d",
							$time, got_word.mv, $signed(got_word.deg), got_word.fac,
							capacity_factor_q15);
						errs = errs + 1;
					end
				end
			end
			if (start && !busy) begin
				pair = predict_capacity(cell_voltage_mv, temperature_c, full_cap);
				got_word.mv = cell_voltage_mv;
				got_word.deg = temperature_c;
				got_word.cap = pair[31:16];
				got_word.fac = pair[15:0];
				capacity_q.push_back(got_word);
			end
			if (psel && penable && pready && paddr == FULL_CAP_ADDR) begin
				if (pwrite) begin
					full_cap <= pwdata[15:0];
				end else if (prdata[15:0] !== full_cap) begin
					$display("%0t: full capacity read: expected %0d, got %0d",
						$time, full_cap, prdata[15:0]);
					errs = errs + 1;
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			pending <= capacity_q.size();
		end
	end

endmodule

// ===== tb/sv/charge_end_capacity_bilinear_test.sv =====
// Top of the charge_end_capacity_bilinear testbench: clock, reset, stimulus, verdict.
// Drives directed and random words over several full-capacity settings.
// Depends on cecb_pkg, the block and cecb_capacity_check.
module charge_end_capacity_bilinear_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cecb_pkg::ADDR_W-1:0] FULL_CAP_ADDR =
		cecb_pkg::ADDR_W'(4 * cecb_pkg::REG_FULL_CAP);
	localparam int WORDS_PER_SETTING = 275;
	localparam int SETTINGS_N = 7;
	localparam int DIRECTED_N = 22;
	localparam int DIR_MV [DIRECTED_N] = '{
		3389, 3388, 0, 8191, 3390, 3399, 3403, 3422, 3440, 3475, 3630,
		3650, 3651, 3649, 5000, 3500, 8191, 3420, 4095, 3389, 3650, 6000
	};
	localparam int DIR_DEG [DIRECTED_N] = '{
		0, -1, -128, 127, 1, 5, 10, 15, 20, 25, 35,
		45, 46, 44, -50, 127, -128, 12, 64, 45, 0, 30
	};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [cecb_pkg::V_W-1:0] cell_voltage_mv;
	logic signed [cecb_pkg::T_W-1:0] temperature_c;
	logic done;
	logic [cecb_pkg::CAP_W-1:0] capacity_centi_ah;
	logic [cecb_pkg::FAC_W-1:0] capacity_factor_q15;
	logic psel;
	logic penable;
	logic pwrite;
	logic [cecb_pkg::ADDR_W-1:0] paddr;
	logic [cecb_pkg::APB_DW-1:0] pwdata;
	logic [cecb_pkg::APB_DW-1:0] prdata;
	logic pready;
	int fail_count;
	int pending;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	charge_end_capacity_bilinear dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cell_voltage_mv(cell_voltage_mv), .temperature_c(temperature_c),
		.done(done), .capacity_centi_ah(capacity_centi_ah),
		.capacity_factor_q15(capacity_factor_q15),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cecb_capacity_check cap_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cell_voltage_mv(cell_voltage_mv), .temperature_c(temperature_c),
		.done(done), .capacity_centi_ah(capacity_centi_ah),
		.capacity_factor_q15(capacity_factor_q15),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.fail_count(fail_count), .pending(pending)
	);

	task automatic send_word(input logic [12:0] mv, input logic [7:0] deg);
		start <= 1'b1;
		cell_voltage_mv <= mv;
		temperature_c <= deg;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		@(negedge clk);
	endtask

	task automatic hold_off(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(negedge clk);
		end
	endtask

	task automatic random_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			hold_off(0);
		else if (roll < 95)
			hold_off($urandom_range(1, 3));
		else
			hold_off($urandom_range(8, 50));
	endtask

	task automatic drain();
		hold_off(1);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [cecb_pkg::APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= FULL_CAP_ADDR;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int k;
		int s;
		int deg;
		logic [15:0] full_setting;
		start = 1'b0;
		cell_voltage_mv = '0;
		temperature_c = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		apb_access(1'b0, '0);

		for (k = 0; k < DIRECTED_N; k++) begin
			deg = DIR_DEG[k];
			send_word(13'(DIR_MV[k]), deg[7:0]);
			if (k % 3 == 2)
				hold_off(k % 5);
		end

		for (s = 0; s < SETTINGS_N; s++) begin
			drain();
			case (s)
				0: full_setting = 16'd1;
				1: full_setting = 16'hFFFF;
				2: full_setting = 16'd0;
				3: full_setting = 16'($urandom_range(1, 65535));
				4: full_setting = 16'd11900;
				5: full_setting = 16'($urandom_range(100, 20000));
				default: full_setting = 16'd12000;
			endcase
			apb_access(1'b1, {16'd0, full_setting});
			apb_access(1'b0, '0);
			for (k = 0; k < WORDS_PER_SETTING; k++) begin
				if ($urandom_range(0, 9) < 6) begin
					deg = $urandom_range(0, 60);
					deg = deg - 5;
					send_word(13'($urandom_range(3370, 3670)), deg[7:0]);
				end else begin
					send_word(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
				end
				if (k >= 40)
					random_gap();
			end
		end

		drain();
		repeat (cecb_pkg::LATENCY + 10) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cecb_pkg.sv
rtl/core/cecb_div.sv
rtl/core/charge_end_capacity_bilinear.sv
tb/sv/cecb_capacity_check.sv
tb/sv/charge_end_capacity_bilinear_test.sv
